// ----- rtl/bit_sliced_index_range_filter_top_macros.svh -----
// Assertion macros used by the checker file of the range filter.
`ifndef BIT_SLICED_INDEX_RANGE_FILTER_TOP_MACROS_SVH
`define BIT_SLICED_INDEX_RANGE_FILTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BSIRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsirf check failed");

// Next-cycle implication, disabled while reset is held.
`define BSIRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsirf check failed");

`endif

// ----- rtl/bsirf_pkg.sv -----
// Package with types, codes and widths of the bit-sliced index range filter.
`timescale 1ns / 1ps
package bsirf_pkg;

    // Default sizing of the index.
    localparam int DEF_ROWS       = 4096;
    localparam int DEF_WORD_BITS  = 64;
    localparam int DEF_MAX_SLICES = 31;

    // Field widths of the stream items.
    localparam int CMD_W      = 2;
    localparam int ROW_ID_W   = 12;
    localparam int OPERAND_W  = 32;
    localparam int VALUE_W    = 31;
    localparam int WIDX_W     = 6;
    localparam int ROW_BITS_W = 64;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 72;
    localparam int ROW_CMP_W  = 17;

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 1'd1;

    // Command carried in the input item.
    typedef enum logic [CMD_W-1:0] {
        OP_APPEND = 2'd0,
        OP_EQ     = 2'd1,
        OP_GT     = 2'd2,
        OP_GTE    = 2'd3
    } t_op;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ROW_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_VALUE_RANGE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic load;
        logic step;
        logic emit;
        logic word_inc;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic slice_last;
        logic word_last;
        logic is_append;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/bsirf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module bsirf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bsirf_ctrl.sv -----
// Controller state machine of the range filter: clearing, slice walk and result hand-off.
`timescale 1ns / 1ps
module bsirf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    input  bsirf_pkg::t_dp_sts i_sts,
    output logic              o_s_ready,
    output bsirf_pkg::t_dp_cmd o_cmd
);
    import bsirf_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_WALK  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_valid) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.slice_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    if (i_sts.is_append || i_sts.word_last) n_state = S_IDLE;
                    else n_state = S_WALK;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands decoded from the state.
    always_comb begin
        o_s_ready      = (r_state == S_IDLE);
        o_cmd.clr      = (r_state == S_CLEAR);
        o_cmd.load     = (r_state == S_IDLE) && i_s_valid;
        o_cmd.step     = (r_state == S_WALK);
        o_cmd.emit     = (r_state == S_EMIT) && i_sts.out_free;
        o_cmd.word_inc = (r_state == S_EMIT) && i_sts.out_free
                         && !i_sts.is_append && !i_sts.word_last;
    end

endmodule

// ----- rtl/bsirf_dp.sv -----
// Datapath of the range filter: registers, bitmap memories, slice accumulator, output stage.
`timescale 1ns / 1ps
module bsirf_dp #(
    parameter int ROWS       = bsirf_pkg::DEF_ROWS,
    parameter int WORD_BITS  = bsirf_pkg::DEF_WORD_BITS,
    parameter int MAX_SLICES = bsirf_pkg::DEF_MAX_SLICES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bsirf_pkg::t_dp_cmd                  i_cmd,
    output bsirf_pkg::t_dp_sts                  o_sts,
    input  logic [bsirf_pkg::CMD_W-1:0]         i_s_cmd,
    input  logic [bsirf_pkg::ROW_ID_W-1:0]      i_s_row_id,
    input  logic [bsirf_pkg::OPERAND_W-1:0]     i_s_operand,
    input  logic                                i_cfg_we,
    input  logic [bsirf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bsirf_pkg::VALUE_W-1:0]       i_cfg_data,
    output logic                                o_m_valid,
    input  logic                                i_m_ready,
    output logic [bsirf_pkg::WIDX_W-1:0]        o_m_word_index,
    output logic [bsirf_pkg::ROW_BITS_W-1:0]    o_m_row_bits,
    output logic                                o_m_last,
    output logic [bsirf_pkg::STATUS_W-1:0]      o_m_status
);
    import bsirf_pkg::*;

    localparam int WORDS  = ROWS / WORD_BITS;
    localparam int WW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SW     = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int SDEPTH = MAX_SLICES * WORDS;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int BW     = $clog2(WORD_BITS);

    // Configuration registers and the derived slice-use mask.
    logic [VALUE_W-1:0]    r_min;
    logic [VALUE_W-1:0]    r_max;
    logic [MAX_SLICES-1:0] r_mask;
    logic [MAX_SLICES-1:0] n_mask;

    // Captured item.
    t_op                   r_op;
    logic [OPERAND_W-1:0]  r_code;
    logic                  r_all;
    logic [WW-1:0]         r_row_word;
    logic [WORD_BITS-1:0]  r_row_bit;
    logic [STATUS_W-1:0]   r_status;

    // Sequencing counters.
    logic [SW-1:0]         r_slice;
    logic [WW-1:0]         r_word;
    logic [SAW-1:0]        r_clr;

    // Read pipeline tags.
    logic                  r_p1_v;
    logic                  r_p1_first;
    logic [SW-1:0]         r_p1_slice;
    logic [SAW-1:0]        r_p1_addr;

    // Accumulator.
    logic [WORD_BITS-1:0]  r_acc;
    logic [WORD_BITS-1:0]  n_acc;
    logic                  r_started;
    logic                  n_started;
    logic [WORD_BITS-1:0]  r_pres;

    // Output stage.
    logic                  r_out_v;
    logic [WIDX_W-1:0]     r_out_widx;
    logic [ROW_BITS_W-1:0] r_out_bits;
    logic                  r_out_last;
    logic [STATUS_W-1:0]   r_out_status;

    // Memory ports.
    logic                  s_we;
    logic [SAW-1:0]        s_waddr;
    logic [WORD_BITS-1:0]  s_wdata;
    logic [SAW-1:0]        s_raddr;
    logic [WORD_BITS-1:0]  s_rdata;
    logic                  p_we;
    logic [WW-1:0]         p_waddr;
    logic [WORD_BITS-1:0]  p_wdata;
    logic                  p_re;
    logic [WORD_BITS-1:0]  p_rdata;

    logic [WW-1:0]         word_sel;
    logic [ROW_CMP_W-1:0]  row_ext;
    logic [ROW_CMP_W-1:0]  row_word_ext;
    logic [STATUS_W-1:0]   load_status;
    logic                  load_all;
    logic [WORD_BITS-1:0]  res_bits;
    logic                  out_free;
    logic                  clr_in_pres;
    logic                  code_bit;
    logic                  slice_used;

    // Slice i takes part when max_value has a set bit at i or above; slice 0 always does.
    always_comb begin
        for (int i = 0; i < MAX_SLICES; i++) begin
            n_mask[i] = (i == 0) || ((i_cfg_data >> i) != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '0;
            r_max  <= '1;
            r_mask <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_VALUE: r_min <= i_cfg_data;
                CFG_MAX_VALUE: begin
                    r_max  <= i_cfg_data;
                    r_mask <= n_mask;
                end
                default: begin
                end
            endcase
        end
    end

    // Append checks and query code preparation at item capture.
    always_comb begin
        row_ext      = ROW_CMP_W'(i_s_row_id);
        row_word_ext = row_ext >> BW;
        if (row_ext >= ROW_CMP_W'(ROWS)) begin
            load_status = ST_ROW_RANGE;
        end else if (i_s_operand[OPERAND_W-1]
                     || (i_s_operand[VALUE_W-1:0] < r_min)
                     || (i_s_operand[VALUE_W-1:0] > r_max)) begin
            load_status = ST_VALUE_RANGE;
        end else begin
            load_status = ST_OK;
        end
        // A negative greater code, or a greater-or-equal code of zero or below, takes all rows.
        load_all = ((t_op'(i_s_cmd) == OP_GT) && i_s_operand[OPERAND_W-1])
                   || ((t_op'(i_s_cmd) == OP_GTE)
                       && (i_s_operand[OPERAND_W-1] || (i_s_operand == '0)));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_op'(i_s_cmd);
            r_code     <= (t_op'(i_s_cmd) == OP_GTE) ? (i_s_operand - OPERAND_W'(1))
                                                     : i_s_operand;
            r_all      <= load_all;
            r_row_word <= row_word_ext[WW-1:0];
            r_row_bit  <= WORD_BITS'(1) << i_s_row_id[BW-1:0];
            r_status   <= load_status;
        end
    end

    // Slice, word and clear counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= '0;
            r_word  <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + SAW'(1);
            if (i_cmd.load) begin
                r_slice <= '0;
                r_word  <= '0;
            end else begin
                if (i_cmd.step) begin
                    r_slice <= o_sts.slice_last ? '0 : r_slice + SW'(1);
                end
                if (i_cmd.word_inc) r_word <= r_word + WW'(1);
            end
        end
    end

    // Read addresses: an append visits its own row word, a query the current word.
    assign word_sel = (r_op == OP_APPEND) ? r_row_word : r_word;
    assign s_raddr  = SAW'(SAW'(r_slice) * SAW'(WORDS)) + SAW'(word_sel);
    assign p_re     = i_cmd.step && (r_slice == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_first <= (r_slice == '0);
        r_p1_slice <= r_slice;
        r_p1_addr  <= s_raddr;
    end

    // Write ports: zeroing sweep after reset, read-modify-write on append.
    assign clr_in_pres = ({1'b0, r_clr} < (SAW + 1)'(WORDS));
    assign code_bit    = r_code[r_p1_slice];
    assign slice_used  = r_mask[r_p1_slice];

    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_p1_addr;
        s_wdata = s_rdata | (code_bit ? r_row_bit : '0);
        p_we    = 1'b0;
        p_waddr = r_row_word;
        p_wdata = p_rdata | r_row_bit;
        if (i_cmd.clr) begin
            s_we    = 1'b1;
            s_waddr = r_clr;
            s_wdata = '0;
            p_we    = clr_in_pres;
            p_waddr = r_clr[WW-1:0];
            p_wdata = '0;
        end else if (r_p1_v && (r_op == OP_APPEND) && (r_status == ST_OK)) begin
            s_we = 1'b1;
            p_we = r_p1_first;
        end
    end

    bsirf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (SDEPTH),
        .AW    (SAW)
    ) u_slice_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (i_cmd.step),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    bsirf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (WW)
    ) u_pres_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (word_sel),
        .o_rdata (p_rdata)
    );

    // Slice accumulator. Greater queries start at the lowest zero code bit and
    // then AND on one bits and OR on zero bits; equal queries mask by every used slice bit.
    always_comb begin
        n_acc     = r_p1_first ? ((r_op == OP_EQ) ? p_rdata : '0) : r_acc;
        n_started = r_p1_first ? 1'b0 : r_started;
        if (slice_used) begin
            case (r_op)
                OP_EQ: begin
                    n_acc = n_acc & (code_bit ? s_rdata : ~s_rdata);
                end
                OP_GT, OP_GTE: begin
                    if (!n_started) begin
                        if (!code_bit) begin
                            n_acc     = s_rdata;
                            n_started = 1'b1;
                        end
                    end else begin
                        n_acc = code_bit ? (n_acc & s_rdata) : (n_acc | s_rdata);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_v) begin
            r_acc     <= n_acc;
            r_started <= n_started;
            if (r_p1_first) r_pres <= p_rdata;
        end
    end

    // Final word of a query.
    always_comb begin
        case (r_op)
            OP_EQ:   res_bits = r_acc;
            OP_GT,
            OP_GTE:  res_bits = r_all ? r_pres : (r_started ? (r_acc & r_pres) : '0);
            default: res_bits = '0;
        endcase
    end

    // Output register; it frees when the receiver takes the item.
    assign out_free = !r_out_v || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_v <= 1'b1;
        end else if (i_m_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_op == OP_APPEND) begin
                r_out_widx   <= '0;
                r_out_bits   <= '0;
                r_out_last   <= 1'b1;
                r_out_status <= r_status;
            end else begin
                r_out_widx   <= WIDX_W'(r_word);
                r_out_bits   <= ROW_BITS_W'(res_bits);
                r_out_last   <= o_sts.word_last;
                r_out_status <= ST_OK;
            end
        end
    end

    assign o_m_valid      = r_out_v;
    assign o_m_word_index = r_out_widx;
    assign o_m_row_bits   = r_out_bits;
    assign o_m_last       = r_out_last;
    assign o_m_status     = r_out_status;

    // Status toward the controller.
    always_comb begin
        o_sts.clr_done   = (r_clr == SAW'(SDEPTH - 1));
        o_sts.slice_last = (r_slice == SW'(MAX_SLICES - 1));
        o_sts.word_last  = (r_word == WW'(WORDS - 1));
        o_sts.is_append  = (r_op == OP_APPEND);
        o_sts.out_free   = out_free;
    end

endmodule

// ----- rtl/bit_sliced_index_range_filter_top.sv -----
// Top level of the bit-sliced index range filter.
//
// Input stream: s_axis_tuser carries the command (append, equal, greater,
// greater-or-equal); s_axis_tdata carries row_id and the signed operand.
// Output stream: one item per append with its status in m_axis_tuser, or one
// item per row word for a query, in word order, tlast on the final word.
// Configuration: i_cfg_we writes min_value (index 0) or max_value (index 1).
// Items are handled one at a time; s_axis_tready is high only when idle.
// Every item walks all MAX_SLICES slices through the single read port of the
// slice memory, one slice per cycle, then drains the read pipeline before
// the result is offered; a query repeats the walk for each row word.
// After reset the block zeroes both bitmap memories, one slice word per
// cycle, and takes no item meanwhile. A stalled receiver holds the result in
// the output register and the walk waits before loading the next word.
// WORD_BITS is a power of two.
`timescale 1ns / 1ps
module bit_sliced_index_range_filter_top #(
    parameter int ROWS       = bsirf_pkg::DEF_ROWS,
    parameter int WORD_BITS  = bsirf_pkg::DEF_WORD_BITS,
    parameter int MAX_SLICES = bsirf_pkg::DEF_MAX_SLICES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Bits from low: row_id[11:0], operand[43:12], zero fill[47:44].
    input  logic [bsirf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // Bits from low: cmd[1:0].
    input  logic [bsirf_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Bits from low: word_index[5:0], row_bits[69:6], zero fill[71:70].
    output logic [bsirf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,
    // Bits from low: status[1:0].
    output logic [bsirf_pkg::STATUS_W-1:0]    m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [bsirf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bsirf_pkg::VALUE_W-1:0]     i_cfg_data
);
    import bsirf_pkg::*;

    t_dp_cmd                dp_cmd;
    t_dp_sts                dp_sts;
    logic [WIDX_W-1:0]      m_word_index;
    logic [ROW_BITS_W-1:0]  m_row_bits;

    bsirf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_sts     (dp_sts),
        .o_s_ready (s_axis_tready),
        .o_cmd     (dp_cmd)
    );

    bsirf_dp #(
        .ROWS       (ROWS),
        .WORD_BITS  (WORD_BITS),
        .MAX_SLICES (MAX_SLICES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_s_cmd        (s_axis_tuser),
        .i_s_row_id     (s_axis_tdata[ROW_ID_W-1:0]),
        .i_s_operand    (s_axis_tdata[ROW_ID_W +: OPERAND_W]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_m_valid      (m_axis_tvalid),
        .i_m_ready      (m_axis_tready),
        .o_m_word_index (m_word_index),
        .o_m_row_bits   (m_row_bits),
        .o_m_last       (m_axis_tlast),
        .o_m_status     (m_axis_tuser)
    );

    // Pack the output item.
    assign m_axis_tdata = {(M_TDATA_W - ROW_BITS_W - WIDX_W)'(0), m_row_bits, m_word_index};

endmodule

// ----- rtl/bsirf_chk.sv -----
// Port checker of the range filter, bound to the top level.
`timescale 1ns / 1ps
`include "bit_sliced_index_range_filter_top_macros.svh"
module bsirf_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [bsirf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic                              m_axis_tlast,
    input logic [bsirf_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import bsirf_pkg::*;

    // A stalled result stays offered.
    `BSIRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // A stalled result keeps its payload.
    `BSIRF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // One item at a time: acceptance closes the input until the item is done.
    `BSIRF_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A rejected append is a single final result.
    `BSIRF_ASSERT_NOW(a_err_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tlast)

endmodule

bind bit_sliced_index_range_filter_top bsirf_chk u_bsirf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- sim/tb_bit_sliced_index_range_filter_top.sv -----
// Self-checking testbench for the bit-sliced index range filter top level.
`timescale 1ns / 1ps
module tb_bit_sliced_index_range_filter_top;
    import bsirf_pkg::*;

    localparam int WORDS        = DEF_ROWS / DEF_WORD_BITS;
    localparam int SLICES       = DEF_MAX_SLICES;
    // Lets a finished walk settle before a register write.
    localparam int DRAIN_CYCLES = 2 * (DEF_MAX_SLICES + 3);
    localparam int HOLD_CYCLES  = 600;

    // One expected output item.
    typedef struct packed {
        logic [WIDX_W-1:0]     word_index;
        logic [ROW_BITS_W-1:0] row_bits;
        logic                  last;
        logic [STATUS_W-1:0]   status;
    } t_filter_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = OP_APPEND;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_MIN_VALUE;
    logic [VALUE_W-1:0]    i_cfg_data = '0;

    // Predicted index contents and register values.
    logic [ROW_BITS_W-1:0] row_exists [WORDS];
    logic [ROW_BITS_W-1:0] slice_bits [SLICES][WORDS];
    logic [VALUE_W-1:0]    accept_min;
    logic [VALUE_W-1:0]    accept_max;
    t_filter_word          pending_words [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int error_count    = 0;
    int items_sent     = 0;
    int queries_sent   = 0;
    int cfg_writes     = 0;
    int words_checked  = 0;

    bit_sliced_index_range_filter_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Number of value slices that queries look at: bit length of max, at least one, at most SLICES.
    function automatic int slice_total();
        int n;
        logic [VALUE_W-1:0] v;
        n = 0;
        v = accept_max;
        while (v != '0) begin
            n++;
            v = v >> 1;
        end
        if (n < 1) n = 1;
        if (n > SLICES) n = SLICES;
        return n;
    endfunction

    // Rows of word w holding a value greater than code.
    function automatic logic [ROW_BITS_W-1:0] greater_word(logic [31:0] code, int w, int s);
        int start;
        int i;
        logic [ROW_BITS_W-1:0] acc;
        if (code[31]) return row_exists[w];
        start = 0;
        while (start < 32 && code[start]) start++;
        if (start >= s) return '0;
        acc = slice_bits[start][w];
        for (i = start + 1; i < s; i++) begin
            if (code[i]) acc = acc & slice_bits[i][w];
            else acc = acc | slice_bits[i][w];
        end
        return acc & row_exists[w];
    endfunction

    // Rows of word w whose low s value bits equal those of code.
    function automatic logic [ROW_BITS_W-1:0] equal_word(logic [31:0] code, int w, int s);
        int i;
        logic [ROW_BITS_W-1:0] acc;
        acc = row_exists[w];
        for (i = 0; i < s; i++) begin
            if (code[i]) acc = acc & slice_bits[i][w];
            else acc = acc & ~slice_bits[i][w];
        end
        return acc;
    endfunction

    // Update the predicted index for one accepted item and queue its output items.
    task automatic predict_filter_words(t_op op, logic [ROW_ID_W-1:0] row, logic [31:0] code);
        t_filter_word r;
        int s;
        int w;
        int i;
        s = slice_total();
        if (op == OP_APPEND) begin
            r.word_index = '0;
            r.row_bits   = '0;
            r.last       = 1'b1;
            if (int'(row) >= DEF_ROWS) begin
                r.status = ST_ROW_RANGE;
            end else if (code[31] || code[30:0] < accept_min || code[30:0] > accept_max) begin
                r.status = ST_VALUE_RANGE;
            end else begin
                r.status = ST_OK;
                for (i = 0; i < SLICES; i++) begin
                    if (code[i]) slice_bits[i][row[11:6]][row[5:0]] = 1'b1;
                end
                row_exists[row[11:6]][row[5:0]] = 1'b1;
            end
            pending_words.push_back(r);
        end else begin
            for (w = 0; w < WORDS; w++) begin
                case (op)
                    OP_EQ: r.row_bits = equal_word(code, w, s);
                    OP_GT: r.row_bits = greater_word(code, w, s);
                    default: begin
                        // The minimum code has no predecessor and matches every row.
                        if (code == 32'h8000_0000) r.row_bits = row_exists[w];
                        else r.row_bits = greater_word(code - 32'd1, w, s);
                    end
                endcase
                r.word_index = w[WIDX_W-1:0];
                r.last       = (w == WORDS - 1);
                r.status     = ST_OK;
                pending_words.push_back(r);
            end
        end
    endtask

    // Print one mismatch line and count it.
    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("ERROR at %0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        error_count++;
    endtask

    // Offer one item on the input stream and wait until it is taken.
    task automatic send_item(t_op op, logic [ROW_ID_W-1:0] row, logic [31:0] code);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {4'b0000, code, row};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_filter_words(op, row, code);
        items_sent++;
        if (op != OP_APPEND) queries_sent++;
    endtask

    // Stop offering, let every expected item arrive, then let the block settle.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one configuration register; the block is idle when this is called.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        if (idx == CFG_MIN_VALUE) accept_min = data;
        else accept_max = data;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_range(logic [VALUE_W-1:0] lo, logic [VALUE_W-1:0] hi);
        wait_idle();
        write_register(CFG_MIN_VALUE, lo);
        write_register(CFG_MAX_VALUE, hi);
    endtask

    // Appends at the row and value extremes, plus negative values that must be rejected.
    task automatic test_append_extremes();
        send_item(OP_APPEND, 12'd0, 32'd0);
        send_item(OP_APPEND, 12'd4095, 32'h7FFF_FFFF);
        send_item(OP_APPEND, 12'd63, 32'd5);
        send_item(OP_APPEND, 12'd2000, 32'd1000);
        send_item(OP_APPEND, 12'd1, 32'hFFFF_FFFF);
        send_item(OP_APPEND, 12'd2, 32'h8000_0000);
    endtask

    // Each query kind, with negative codes, a code beyond the slices and the saturating minimum.
    task automatic test_query_codes();
        send_item(OP_EQ, 12'hABC, 32'd5);
        send_item(OP_EQ, 12'h543, 32'h8000_0005);
        send_item(OP_GT, 12'd0, 32'hFFFF_FFFF);
        send_item(OP_GT, 12'hFFF, 32'h7FFF_FFFF);
        send_item(OP_GT, 12'd7, 32'd4);
        send_item(OP_GTE, 12'd0, 32'h8000_0000);
        send_item(OP_GTE, 12'd9, 32'd0);
    endtask

    // Narrow, inverted, single-slice and all-ones ranges, reusing stored slices.
    task automatic test_config_corners();
        set_range(31'd10, 31'd20);
        send_item(OP_APPEND, 12'd100, 32'd9);
        send_item(OP_APPEND, 12'd101, 32'd21);
        send_item(OP_APPEND, 12'd102, 32'd10);
        send_item(OP_APPEND, 12'd103, 32'd20);
        send_item(OP_GT, 12'd0, 32'h0000_001F);
        send_item(OP_EQ, 12'd0, 32'hFFFF_FFF4);
        set_range(31'd100, 31'd50);
        send_item(OP_APPEND, 12'd104, 32'd75);
        set_range(31'd0, 31'd0);
        send_item(OP_APPEND, 12'd105, 32'd0);
        send_item(OP_APPEND, 12'd106, 32'd1);
        send_item(OP_EQ, 12'd0, 32'd1);
        set_range(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_item(OP_APPEND, 12'd107, 32'h7FFF_FFFF);
        send_item(OP_APPEND, 12'd108, 32'h7FFF_FFFE);
    endtask

    // Receiver holds off for a long time while the sender keeps offering items.
    task automatic test_backpressure();
        set_range(31'd0, 31'h0000_FFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        send_item(OP_GT, 12'($urandom_range(0, 4095)), 32'hFFFF_FFFF);
        send_item(OP_APPEND, 12'($urandom_range(0, 4095)), $urandom_range(0, 32'hFFFF));
        send_item(OP_APPEND, 12'($urandom_range(0, 4095)), $urandom_range(0, 32'hFFFF));
        send_item(OP_GTE, 12'($urandom_range(0, 4095)), $urandom_range(0, 32'hFFFF));
    endtask

    // Random range, then mostly in-range appends mixed with queries and some noise.
    task automatic test_random_traffic(int send_pct, int recv_pct, int count);
        int unsigned k;
        int unsigned hi;
        int unsigned lo;
        int unsigned sel;
        logic [31:0] code;
        t_op op;
        k  = $urandom_range(1, 31);
        hi = (32'd1 << (k - 1)) | ($urandom & ((32'd1 << (k - 1)) - 32'd1));
        lo = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, hi / 2);
        set_range(lo[VALUE_W-1:0], hi[VALUE_W-1:0]);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) begin
            sel = $urandom_range(99);
            if (sel < 72) begin
                op = OP_APPEND;
                case ($urandom_range(9))
                    0: code = $urandom;
                    1: code = ($urandom_range(1)) ? {1'b0, accept_min} - 32'd1
                                                  : {1'b0, accept_max} + 32'd1;
                    default: code = $urandom_range(accept_min, accept_max);
                endcase
            end else begin
                op = t_op'($urandom_range(1, 3));
                case ($urandom_range(7))
                    0: code = $urandom;
                    1: begin
                        case ($urandom_range(3))
                            0: code = 32'd0;
                            1: code = 32'hFFFF_FFFF;
                            2: code = 32'h8000_0000;
                            default: code = 32'h7FFF_FFFF;
                        endcase
                    end
                    2: code = ($urandom_range(1)) ? {1'b0, accept_max} : {1'b0, accept_min};
                    default: code = $urandom_range(accept_min, accept_max);
                endcase
            end
            send_item(op, 12'($urandom_range(0, 4095)), code);
        end
    endtask

    // Result ready: random stalls, or a long hold-off counted here when requested.
    always @(negedge i_clk) begin : drive_result_ready
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted output item against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_filter_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("output item with nothing pending, word_index", 64'd0,
                                {58'd0, m_axis_tdata[5:0]});
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (m_axis_tdata[5:0] !== want.word_index)
                    report_mismatch("word_index", want.word_index, m_axis_tdata[5:0]);
                if (m_axis_tdata[69:6] !== want.row_bits)
                    report_mismatch("row_bits", want.row_bits, m_axis_tdata[69:6]);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", want.last, m_axis_tlast);
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", want.status, m_axis_tuser);
            end
        end
    end

    // Test sequence.
    initial begin
        for (int w = 0; w < WORDS; w++) begin
            row_exists[w] = '0;
            for (int i = 0; i < SLICES; i++) slice_bits[i][w] = '0;
        end
        accept_min = '0;
        accept_max = 31'h7FFF_FFFF;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_append_extremes();
        test_query_codes();
        test_config_corners();
        test_backpressure();
        test_random_traffic(0, 0, 65);
        test_random_traffic(83, 0, 65);
        test_random_traffic(0, 83, 65);
        test_random_traffic(10, 10, 65);
        wait_idle();

        $display("Run covered %0d items (%0d queries) over %0d register writes.",
                 items_sent, queries_sent, cfg_writes);
        $display("Checked %0d output items under free, sender-idle, stalled and mixed traffic.",
                 words_checked);
        if (error_count == 0) begin
            $display("PASS bit_sliced_index_range_filter_top");
        end else begin
            $display("FAIL bit_sliced_index_range_filter_top");
        end
        $finish;
    end

    // Generous bound on the whole run.
    initial begin
        #20_000_000;
        $display("Timeout with %0d output items still pending.", pending_words.size());
        $display("FAIL bit_sliced_index_range_filter_top");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bsirf_pkg.sv
rtl/bsirf_ram.sv
rtl/bsirf_ctrl.sv
rtl/bsirf_dp.sv
rtl/bit_sliced_index_range_filter_top.sv
rtl/bsirf_chk.sv
sim/tb_bit_sliced_index_range_filter_top.sv
